### sv/tif_pkg.sv
// ----------------------------------------------------------------------------
// tif_pkg: shared types and constants for the turn indicator flasher
// Holds the switch and lamp codes, register indexes, reset durations and the
// queue entry that passes from the front end to the back end.
// ----------------------------------------------------------------------------
package tif_pkg;

    // Field widths fixed by the item format.
    localparam int SWITCH_W = 8;
    localparam int TIME_W   = 32;
    localparam int LAMP_W   = 3;
    localparam int DUR_W    = 16;
    localparam int SIDE_W   = 2;

    // Turn switch codes.
    localparam logic [SWITCH_W-1:0] SW_NONE   = 8'h00;
    localparam logic [SWITCH_W-1:0] SW_LEFT   = 8'h01;
    localparam logic [SWITCH_W-1:0] SW_RIGHT  = 8'h02;
    localparam logic [SWITCH_W-1:0] SW_CANCEL = 8'h03;

    // Active side encoding (same values as the low bits of the switch code).
    localparam logic [SIDE_W-1:0] SIDE_NONE  = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_LEFT  = 2'd1;

    // Lamp message codes.
    localparam logic [LAMP_W-1:0] LAMP_BOTH_OFF  = 3'd0;
    localparam logic [LAMP_W-1:0] LAMP_LEFT_ON   = 3'd1;
    localparam logic [LAMP_W-1:0] LAMP_RIGHT_ON  = 3'd2;
    localparam logic [LAMP_W-1:0] LAMP_LEFT_OFF  = 3'd3;
    localparam logic [LAMP_W-1:0] LAMP_RIGHT_OFF = 3'd4;

    // Configuration register indexes.
    localparam logic REG_ON_DURATION  = 1'b0;
    localparam logic REG_OFF_DURATION = 1'b1;

    localparam logic [DUR_W-1:0] DURATION_RESET = 16'd300;

    // Default depth of the queue between front and back end.
    localparam int QUEUE_DEPTH_DEF = 2;

    // One queued item: one or two lamp messages.
    typedef struct packed {
        logic              two;
        logic [LAMP_W-1:0] code0;
        logic [LAMP_W-1:0] code1;
    } tif_entry_t;

    // Queue status seen by the consumer.
    typedef struct packed {
        logic empty;
        logic full;
    } tif_qstat_t;

endpackage

### sv/turn_indicator_flasher.sv
// ----------------------------------------------------------------------------
// turn_indicator_flasher: turn signal flasher with lamp message stream
// Detects turn switch presses, runs the on/off flash timer and emits lamp
// messages, up to two per input item.
// ----------------------------------------------------------------------------
// Each input item carries a turn switch code and a millisecond timestamp. A
// left or right press lights that side and emits a both-off message, a cancel
// press emits left-off and then right-off, and while a side is active the lamp
// toggles once the elapsed time reaches the on or off duration, emitting the
// matching message. The front end takes one item per cycle whenever the
// message queue has room; it does the press check, the 32-bit elapsed
// subtract and the duration compare in that cycle. The back end drains the
// queue at one message per cycle, unless m_tready stalls it, via a registered
// output: single-message items pass at one item per cycle, and a two-message
// item sends its messages in turn and leaves the queue with the second. An
// accepted item goes into the queue, then its first message into the output
// register. Durations go through the cfg port (index 0 on time, 1 off time);
// the user must write them only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module turn_indicator_flasher #(
    parameter int QUEUE_DEPTH = tif_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Configuration write port.
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [tif_pkg::DUR_W-1:0] cfg_data,
    // Input item stream.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [39:0]               s_tdata,   // [7:0] switch_code, [39:8] time_ms
    // Lamp message stream.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,   // [2:0] lamp_code, [7:3] zero
    output logic                      m_tlast    // last_of_run
);

    tif_pkg::tif_entry_t        push_entry, head;
    tif_pkg::tif_qstat_t        stat;
    logic                       push, pop, in_fire;
    logic [tif_pkg::LAMP_W-1:0] code;

    // An item is taken whenever the queue can hold its messages.
    assign s_tready = !stat.full;
    assign in_fire  = s_tvalid && s_tready;

    tif_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_fire    (in_fire),
        .in_switch  (s_tdata[7:0]),
        .in_time    (s_tdata[39:8]),
        .push       (push),
        .push_entry (push_entry)
    );

    tif_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (stat)
    );

    tif_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .stat     (stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_code   (code),
        .m_tlast  (m_tlast)
    );

    assign m_tdata = {{(8-tif_pkg::LAMP_W){1'b0}}, code};

endmodule

### sv/tif_front.sv
// ----------------------------------------------------------------------------
// tif_front: press detection, flash timer and message classification
// Accepts one item per cycle, updates the flasher state and pushes the lamp
// messages caused by the item into the queue as a single entry.
// ----------------------------------------------------------------------------
module tif_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [tif_pkg::DUR_W-1:0]           cfg_data,
    input  logic                                in_fire,
    input  logic [tif_pkg::SWITCH_W-1:0]        in_switch,
    input  logic [tif_pkg::TIME_W-1:0]          in_time,
    output logic                                push,
    output tif_pkg::tif_entry_t                 push_entry
);

    logic [tif_pkg::DUR_W-1:0]    on_dur_reg,  on_dur_next;
    logic [tif_pkg::DUR_W-1:0]    off_dur_reg, off_dur_next;
    logic [tif_pkg::SWITCH_W-1:0] prev_sw_reg, prev_sw_next;
    logic [tif_pkg::SIDE_W-1:0]   side_reg,    side_next;
    logic                         lit_reg,     lit_next;
    logic [tif_pkg::TIME_W-1:0]   ts_reg,      ts_next;

    logic                         press, cancel, select;
    logic [tif_pkg::SIDE_W-1:0]   side_a;
    logic                         lit_a;
    logic [tif_pkg::TIME_W-1:0]   ts_a;
    logic [tif_pkg::TIME_W-1:0]   elapsed;
    logic [tif_pkg::DUR_W-1:0]    limit;
    logic                         toggle;
    logic [tif_pkg::LAMP_W-1:0]   toggle_code;

    // The press is applied first; the timer check then sees the updated state.
    always_comb begin
        press  = (in_switch != prev_sw_reg) && (in_switch != tif_pkg::SW_NONE);
        cancel = press && (in_switch == tif_pkg::SW_CANCEL);
        select = press && ((in_switch == tif_pkg::SW_LEFT) ||
                           (in_switch == tif_pkg::SW_RIGHT));

        side_a = cancel ? tif_pkg::SIDE_NONE :
                 select ? in_switch[tif_pkg::SIDE_W-1:0] : side_reg;
        lit_a  = cancel ? 1'b0 : (select ? 1'b1 : lit_reg);
        ts_a   = select ? in_time : ts_reg;

        elapsed = in_time - ts_a;
        limit   = lit_a ? on_dur_reg : off_dur_reg;
        toggle  = (side_a != tif_pkg::SIDE_NONE) &&
                  (elapsed >= {{(tif_pkg::TIME_W-tif_pkg::DUR_W){1'b0}}, limit});

        // The lamp takes the inverted state after a toggle.
        if (side_a == tif_pkg::SIDE_LEFT) begin
            toggle_code = lit_a ? tif_pkg::LAMP_LEFT_OFF : tif_pkg::LAMP_LEFT_ON;
        end else begin
            toggle_code = lit_a ? tif_pkg::LAMP_RIGHT_OFF : tif_pkg::LAMP_RIGHT_ON;
        end
    end

    always_comb begin
        push_entry.two   = 1'b0;
        push_entry.code0 = toggle_code;
        push_entry.code1 = toggle_code;
        push             = 1'b0;
        priority if (cancel) begin
            push_entry.two   = 1'b1;
            push_entry.code0 = tif_pkg::LAMP_LEFT_OFF;
            push_entry.code1 = tif_pkg::LAMP_RIGHT_OFF;
            push             = in_fire;
        end else if (select) begin
            push_entry.two   = toggle;
            push_entry.code0 = tif_pkg::LAMP_BOTH_OFF;
            push             = in_fire;
        end else if (toggle) begin
            push             = in_fire;
        end
    end

    always_comb begin
        on_dur_next  = on_dur_reg;
        off_dur_next = off_dur_reg;
        prev_sw_next = prev_sw_reg;
        side_next    = side_reg;
        lit_next     = lit_reg;
        ts_next      = ts_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                tif_pkg::REG_ON_DURATION:  on_dur_next  = cfg_data;
                tif_pkg::REG_OFF_DURATION: off_dur_next = cfg_data;
                default:                   on_dur_next  = on_dur_reg;
            endcase
        end
        if (in_fire) begin
            prev_sw_next = in_switch;
            side_next    = side_a;
            lit_next     = toggle ? ~lit_a : lit_a;
            ts_next      = toggle ? in_time : ts_a;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_dur_reg  <= tif_pkg::DURATION_RESET;
            off_dur_reg <= tif_pkg::DURATION_RESET;
            prev_sw_reg <= tif_pkg::SW_NONE;
            side_reg    <= tif_pkg::SIDE_NONE;
            lit_reg     <= 1'b0;
            ts_reg      <= '0;
        end else begin
            on_dur_reg  <= on_dur_next;
            off_dur_reg <= off_dur_next;
            prev_sw_reg <= prev_sw_next;
            side_reg    <= side_next;
            lit_reg     <= lit_next;
            ts_reg      <= ts_next;
        end
    end

endmodule

### sv/tif_fifo.sv
// ----------------------------------------------------------------------------
// tif_fifo: short queue of message entries
// Register-based first-in first-out queue between front and back end.
// ----------------------------------------------------------------------------
module tif_fifo #(
    parameter int DEPTH = tif_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  tif_pkg::tif_entry_t push_entry,
    input  logic                pop,
    output tif_pkg::tif_entry_t head,
    output tif_pkg::tif_qstat_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tif_pkg::tif_entry_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg,    cnt_next;
    logic          do_push, do_pop;

    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == CW'(DEPTH));
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### sv/tif_back.sv
// ----------------------------------------------------------------------------
// tif_back: message sequencer and output register
// Takes queue entries and sends their one or two lamp messages in order.
// ----------------------------------------------------------------------------
module tif_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tif_pkg::tif_entry_t        head,
    input  tif_pkg::tif_qstat_t        stat,
    output logic                       pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [tif_pkg::LAMP_W-1:0] m_code,
    output logic                       m_tlast
);

    logic                       valid_reg, valid_next;
    logic                       phase_reg, phase_next;
    logic [tif_pkg::LAMP_W-1:0] code_reg,  code_next;
    logic                       last_reg,  last_next;
    logic                       load, last_msg;

    assign load     = (!valid_reg || m_tready) && !stat.empty;
    assign last_msg = !head.two || phase_reg;
    assign pop      = load && last_msg;

    always_comb begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        code_next  = code_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = 1'b1;
            code_next  = phase_reg ? head.code1 : head.code0;
            last_next  = last_msg;
            phase_next = !last_msg;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_code   = code_reg;
    assign m_tlast  = last_reg;

endmodule
